/* sv/accel_tilt_rotation_matrix_defines.svh */
// Assertion macros for the tilt rotation matrix block.
// Included by the top level; needs clk_i and rst_ni in the including scope.
`ifndef ACCEL_TILT_ROTATION_MATRIX_DEFINES_SVH
`define ACCEL_TILT_ROTATION_MATRIX_DEFINES_SVH

// Check a property on every rising edge outside reset.
`define ATRM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Check that a condition is followed by a consequence in the next cycle.
`define ATRM_ASSERT_NEXT(lbl, ante, cons, msg) \
  `ATRM_ASSERT(lbl, (ante) |=> (cons), msg)

`endif

/* sv/atrm_pkg.sv */
// Shared types and constants for the tilt rotation matrix block.
// No dependencies.
package atrm_pkg;

  localparam int SAMPLE_WIDTH_DEF = 16;
  localparam int FRAC_BITS_DEF    = 14;
  localparam int NUM_LANES        = 8;

  localparam logic [1:0] FRAME_WIN = 2'd2;

  typedef enum logic [1:0] {
    CASE_GENERAL  = 2'd0,
    CASE_FREEFALL = 2'd1,
    CASE_LOCK     = 2'd2
  } case_e;

  // Side information that travels with the lanes of one sample.
  typedef struct packed {
    logic                 valid;
    case_e                code;
    logic                 win;
    logic                 xn;
    logic                 yn;
    logic [NUM_LANES-1:0] neg;
  } meta_t;

endpackage

/* sv/atrm_front.sv */
// Front end: magnitudes, squares, sums, case decision and lane operands.
// Three register stages. Depends on atrm_pkg.
module atrm_front #(
  parameter int SW = atrm_pkg::SAMPLE_WIDTH_DEF,
  parameter int DW = 4 * SW
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  logic                 valid_i,
  input  logic                 win_i,
  input  logic signed [SW-1:0] x_i,
  input  logic signed [SW-1:0] y_i,
  input  logic signed [SW-1:0] z_i,
  output logic [DW-1:0]        num_o [atrm_pkg::NUM_LANES],
  output logic [DW-1:0]        den_o [atrm_pkg::NUM_LANES],
  output atrm_pkg::meta_t      meta_o
);

  localparam int SQW = 2 * SW - 1;
  localparam int SSW = 2 * SW;
  localparam int PW  = 2 * SQW;

  // stage 1: magnitudes and products
  logic [SW-1:0]  ax, ay, az;
  logic [SSW-1:0] ax_w, ay_w, az_w;
  logic [SSW-1:0] xx_f, yy_f, zz_f, pxy_f, pxz_f, pyz_f;

  assign ax = x_i[SW-1] ? SW'(~x_i + 1'b1) : $unsigned(x_i);
  assign ay = y_i[SW-1] ? SW'(~y_i + 1'b1) : $unsigned(y_i);
  assign az = z_i[SW-1] ? SW'(~z_i + 1'b1) : $unsigned(z_i);
  assign ax_w  = SSW'(ax);
  assign ay_w  = SSW'(ay);
  assign az_w  = SSW'(az);
  assign xx_f  = ax_w * ax_w;
  assign yy_f  = ay_w * ay_w;
  assign zz_f  = az_w * az_w;
  assign pxy_f = ax_w * ay_w;
  assign pxz_f = ax_w * az_w;
  assign pyz_f = ay_w * az_w;

  logic           v1_q, v2_q;
  logic           win1_q, win2_q;
  logic           xn1_q, yn1_q, zn1_q, xn2_q, yn2_q, zn2_q;
  logic [SQW-1:0] xx1_q, yy1_q, zz1_q, pxy1_q, pxz1_q, pyz1_q;

  // stage 2: sums and squared products
  logic [SSW-1:0] s_d, t_d;
  logic [PW-1:0]  pxy_w, p2_w, pxy2_d, p2_d;
  logic [SSW-1:0] s2_q, t2_q;
  logic [SQW-1:0] xx2_q, yy2_q, zz2_q;
  logic [PW-1:0]  pxy2_q, p22_q;

  assign s_d    = SSW'(xx1_q) + SSW'(yy1_q) + SSW'(zz1_q);
  assign t_d    = win1_q ? (SSW'(xx1_q) + SSW'(zz1_q)) : (SSW'(yy1_q) + SSW'(zz1_q));
  assign pxy_w  = PW'(pxy1_q);
  assign p2_w   = win1_q ? PW'(pyz1_q) : PW'(pxz1_q);
  assign pxy2_d = pxy_w * pxy_w;
  assign p2_d   = p2_w * p2_w;

  // stage 3: lane operands
  logic [DW-1:0]  s_w, t_w, st_d;
  logic [DW-1:0]  num_d [atrm_pkg::NUM_LANES];
  logic [DW-1:0]  den_d [atrm_pkg::NUM_LANES];
  atrm_pkg::meta_t meta_d;

  assign s_w  = DW'(s2_q);
  assign t_w  = DW'(t2_q);
  assign st_d = s_w * t_w;

  always_comb begin
    num_d[0] = DW'(xx2_q);
    den_d[0] = s_w;
    num_d[1] = DW'(yy2_q);
    den_d[1] = s_w;
    num_d[2] = DW'(zz2_q);
    den_d[2] = s_w;
    num_d[3] = t_w;
    den_d[3] = s_w;
    num_d[4] = DW'(pxy2_q);
    den_d[4] = st_d;
    num_d[5] = DW'(p22_q);
    den_d[5] = st_d;
    num_d[6] = DW'(zz2_q);
    den_d[6] = t_w;
    num_d[7] = win2_q ? DW'(xx2_q) : DW'(yy2_q);
    den_d[7] = t_w;

    meta_d.valid = v2_q;
    meta_d.win   = win2_q;
    meta_d.xn    = xn2_q;
    meta_d.yn    = yn2_q;
    if (s2_q == '0) begin
      meta_d.code = atrm_pkg::CASE_FREEFALL;
    end else if (t2_q == '0) begin
      meta_d.code = atrm_pkg::CASE_LOCK;
    end else begin
      meta_d.code = atrm_pkg::CASE_GENERAL;
    end
    if (win2_q) begin
      meta_d.neg = {xn2_q == zn2_q, 1'b0, yn2_q, xn2_q ^ yn2_q ^ zn2_q,
                    !zn2_q, !zn2_q, !yn2_q, !xn2_q};
    end else begin
      meta_d.neg = {!yn2_q, zn2_q, xn2_q == zn2_q, xn2_q == yn2_q,
                    1'b0, zn2_q, yn2_q, xn2_q};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q   <= 1'b0;
      v2_q   <= 1'b0;
      meta_o <= '0;
    end else if (en_i) begin
      v1_q   <= valid_i;
      v2_q   <= v1_q;
      meta_o <= meta_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      win1_q <= win_i;
      xn1_q  <= x_i[SW-1];
      yn1_q  <= y_i[SW-1];
      zn1_q  <= z_i[SW-1];
      xx1_q  <= xx_f[SQW-1:0];
      yy1_q  <= yy_f[SQW-1:0];
      zz1_q  <= zz_f[SQW-1:0];
      pxy1_q <= pxy_f[SQW-1:0];
      pxz1_q <= pxz_f[SQW-1:0];
      pyz1_q <= pyz_f[SQW-1:0];

      win2_q <= win1_q;
      xn2_q  <= xn1_q;
      yn2_q  <= yn1_q;
      zn2_q  <= zn1_q;
      s2_q   <= s_d;
      t2_q   <= t_d;
      xx2_q  <= xx1_q;
      yy2_q  <= yy1_q;
      zz2_q  <= zz1_q;
      pxy2_q <= pxy2_d;
      p22_q  <= p2_d;

      num_o  <= num_d;
      den_o  <= den_d;
    end
  end

endmodule

/* sv/atrm_div.sv */
// Pipelined restoring divider, one quotient bit per stage.
// Gives floor(num * 2^(QW-1) / den). No dependencies.
module atrm_div #(
  parameter int DW = 64,
  parameter int QW = 31
) (
  input  logic          clk_i,
  input  logic          en_i,
  input  logic [DW-1:0] num_i,
  input  logic [DW-1:0] den_i,
  output logic [QW-1:0] quo_o
);

  logic [DW:0]   rem_q [QW];
  logic [DW-1:0] den_q [QW];
  logic [QW-1:0] quo_q [QW];

  for (genvar i = 0; i < QW; i++) begin : g_stage
    logic [DW:0]   trial;
    logic [DW-1:0] den_in;
    logic [QW-1:0] quo_in;
    logic [DW+1:0] sub;
    logic          ge;

    if (i == 0) begin : g_first
      assign trial  = {1'b0, num_i};
      assign den_in = den_i;
      assign quo_in = '0;
    end else begin : g_next
      assign trial  = {rem_q[i-1][DW-1:0], 1'b0};
      assign den_in = den_q[i-1];
      assign quo_in = quo_q[i-1];
    end

    assign sub = {1'b0, trial} - {2'b00, den_in};
    assign ge  = !sub[DW+1];

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[i] <= ge ? sub[DW:0] : trial;
        den_q[i] <= den_in;
        quo_q[i] <= {quo_in[QW-2:0], ge};
      end
    end
  end

  assign quo_o = quo_q[QW-1];

endmodule

/* sv/atrm_sqrt.sv */
// Pipelined integer square root, one root bit per stage.
// Gives floor(sqrt(val)). No dependencies.
module atrm_sqrt #(
  parameter int QW = 31,
  parameter int RW = 16
) (
  input  logic          clk_i,
  input  logic          en_i,
  input  logic [QW-1:0] val_i,
  output logic [RW-1:0] root_o
);

  localparam int RDW = 2 * RW;

  logic [RDW-1:0] rad_q  [RW];
  logic [RW+1:0]  rem_q  [RW];
  logic [RW-1:0]  root_q [RW];

  for (genvar j = 0; j < RW; j++) begin : g_stage
    logic [RDW-1:0] rad_in;
    logic [RW+1:0]  rem_in;
    logic [RW-1:0]  root_in;
    logic [RW+1:0]  rem_sh, trial;
    logic [RW+2:0]  sub;
    logic           ge;

    if (j == 0) begin : g_first
      assign rad_in  = RDW'(val_i);
      assign rem_in  = '0;
      assign root_in = '0;
    end else begin : g_next
      assign rad_in  = rad_q[j-1];
      assign rem_in  = rem_q[j-1];
      assign root_in = root_q[j-1];
    end

    assign rem_sh = {rem_in[RW-1:0], rad_in[RDW-1:RDW-2]};
    assign trial  = {root_in, 2'b01};
    assign sub    = {1'b0, rem_sh} - {1'b0, trial};
    assign ge     = !sub[RW+2];

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rad_q[j]  <= {rad_in[RDW-3:0], 2'b00};
        rem_q[j]  <= ge ? sub[RW+1:0] : rem_sh;
        root_q[j] <= {root_in[RW-2:0], ge};
      end
    end
  end

  assign root_o = root_q[RW-1];

endmodule

/* sv/accel_tilt_rotation_matrix.sv */
// Top level of the accelerometer tilt rotation matrix block.
// Uses atrm_pkg, atrm_front, atrm_div, atrm_sqrt and the assertion header.
//
// Usage:
//   Slave stream: one beat is one sample, tdata = {z, y, x}, x lowest.
//   Master stream: one beat is one 3x3 matrix in Q1.(FRAC_BITS), row by row,
//   r00 lowest; tuser carries the case code (general, freefall, gimbal lock).
//   APB port: one register, frame_mode, at byte address 0 (NED, the frame
//   equal to NED, or the Windows-style frame). Write it only while idle.
// Pipeline: eight lanes each run a divider with one stage per quotient bit
//   (2*FRAC_BITS + 3) and a square root with one stage per root bit
//   (FRAC_BITS + 2); these set the depth.
// Throughput: one beat per cycle while the receiver keeps up.
// Stall: the pipeline keeps advancing while its last stage holds a bubble,
//   so new beats are taken even when a finished matrix waits in the output
//   register; it freezes only when a second finished matrix would collide.
// Reset: all valid bits clear, frame_mode returns to NED.
`include "accel_tilt_rotation_matrix_defines.svh"

module accel_tilt_rotation_matrix #(
  parameter int SAMPLE_WIDTH = atrm_pkg::SAMPLE_WIDTH_DEF,
  parameter int FRAC_BITS    = atrm_pkg::FRAC_BITS_DEF,
  parameter int IN_W         = ((3 * SAMPLE_WIDTH + 7) / 8) * 8,
  parameter int OUT_W        = ((9 * (FRAC_BITS + 2) + 7) / 8) * 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  // slave stream: accel_x, accel_y, accel_z (lowest first)
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  input  logic [IN_W-1:0]  s_axis_tdata,
  // master stream: r00 r01 r02 r10 r11 r12 r20 r21 r22 (lowest first)
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  output logic [OUT_W-1:0] m_axis_tdata,
  // case_code
  output logic [1:0]       m_axis_tuser,
  // configuration
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [2:0]       paddr,
  input  logic [31:0]      pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  localparam int SW    = SAMPLE_WIDTH;
  localparam int EW    = FRAC_BITS + 2;
  localparam int QW    = 2 * FRAC_BITS + 3;
  localparam int RW    = FRAC_BITS + 2;
  localparam int DW    = 4 * SW;
  localparam int PIPE  = QW + RW;
  localparam int NL    = atrm_pkg::NUM_LANES;

  localparam logic [EW-1:0] ONE     = {2'b01, {FRAC_BITS{1'b0}}};
  localparam logic [EW-1:0] NEG_ONE = {2'b11, {FRAC_BITS{1'b0}}};

  // configuration register
  logic [1:0] frame_q;

  assign pready = 1'b1;
  assign prdata = 32'(frame_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_q <= 2'd0;
    end else if (psel && penable && pwrite && !paddr[2]) begin
      frame_q <= pwdata[1:0];
    end
  end

  // global advance: freeze only when the last stage holds a result and the
  // output register cannot give up its own
  logic            en;
  atrm_pkg::meta_t meta_q [PIPE];
  logic            out_valid_q;

  assign en            = !(meta_q[PIPE-1].valid && out_valid_q && !m_axis_tready);
  assign s_axis_tready = en;

  // input register
  logic                 in_valid_q;
  logic                 in_win_q;
  logic signed [SW-1:0] x_q, y_q, z_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (en) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      x_q      <= $signed(s_axis_tdata[SW-1:0]);
      y_q      <= $signed(s_axis_tdata[2*SW-1:SW]);
      z_q      <= $signed(s_axis_tdata[3*SW-1:2*SW]);
      in_win_q <= (frame_q == atrm_pkg::FRAME_WIN);
    end
  end

  // front end
  logic [DW-1:0]   num [NL];
  logic [DW-1:0]   den [NL];
  atrm_pkg::meta_t front_meta;

  atrm_front #(
    .SW (SW),
    .DW (DW)
  ) u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (in_valid_q),
    .win_i   (in_win_q),
    .x_i     (x_q),
    .y_i     (y_q),
    .z_i     (z_q),
    .num_o   (num),
    .den_o   (den),
    .meta_o  (front_meta)
  );

  // side information travels alongside the divider and root stages
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < PIPE; k++) begin
        meta_q[k] <= '0;
      end
    end else if (en) begin
      meta_q[0] <= front_meta;
      for (int k = 1; k < PIPE; k++) begin
        meta_q[k] <= meta_q[k-1];
      end
    end
  end

  // lanes: divide, root, round half away from zero, apply sign
  logic [EW-1:0] lane [NL];

  for (genvar l = 0; l < NL; l++) begin : g_lane
    logic [QW-1:0] quo;
    logic [RW-1:0] root;
    logic [RW:0]   rsum;
    logic [EW-1:0] mag;

    atrm_div #(
      .DW (DW),
      .QW (QW)
    ) u_div (
      .clk_i (clk_i),
      .en_i  (en),
      .num_i (num[l]),
      .den_i (den[l]),
      .quo_o (quo)
    );

    atrm_sqrt #(
      .QW (QW),
      .RW (RW)
    ) u_sqrt (
      .clk_i  (clk_i),
      .en_i   (en),
      .val_i  (quo),
      .root_o (root)
    );

    // largest odd value under the root gives the rounded magnitude
    assign rsum    = {1'b0, root} + (RW + 1)'(1);
    assign mag     = rsum[RW:1];
    assign lane[l] = meta_q[PIPE-1].neg[l] ? (~mag + 1'b1) : mag;
  end

  // matrix assembly
  atrm_pkg::meta_t      last;
  logic [8:0][EW-1:0]   ent_d;
  logic [8:0][EW-1:0]   ent_q;
  logic [1:0]           code_q;

  assign last = meta_q[PIPE-1];

  always_comb begin
    ent_d = '0;
    case (last.code)
      atrm_pkg::CASE_FREEFALL: begin
        ent_d[0] = ONE;
        ent_d[4] = ONE;
        ent_d[8] = ONE;
      end
      atrm_pkg::CASE_LOCK: begin
        if (last.win) begin
          ent_d[0] = ONE;
          ent_d[5] = last.yn ? ONE : NEG_ONE;
          ent_d[7] = last.yn ? NEG_ONE : ONE;
        end else begin
          ent_d[4] = ONE;
          ent_d[2] = last.xn ? NEG_ONE : ONE;
          ent_d[6] = last.xn ? ONE : NEG_ONE;
        end
      end
      default: begin
        ent_d[2] = lane[0];
        ent_d[5] = lane[1];
        ent_d[8] = lane[2];
        ent_d[0] = last.win ? lane[6] : lane[3];
        ent_d[4] = last.win ? lane[3] : lane[6];
        ent_d[3] = last.win ? '0 : lane[4];
        ent_d[1] = last.win ? lane[4] : '0;
        ent_d[6] = last.win ? lane[7] : lane[5];
        ent_d[7] = last.win ? lane[5] : lane[7];
      end
    endcase
  end

  // output register: load a finished matrix, drop the beat once taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en && last.valid) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en && last.valid) begin
      ent_q  <= ent_d;
      code_q <= last.code;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = OUT_W'(ent_q);
  assign m_axis_tuser  = code_q;

  // checks
  `ATRM_ASSERT(a_stall_only_on_hold, !s_axis_tready |-> (m_axis_tvalid && !m_axis_tready), "input stalled without a held result")
  `ATRM_ASSERT_NEXT(a_result_lands, en && last.valid, m_axis_tvalid, "finished matrix not presented")
  `ATRM_ASSERT(a_freefall_identity, (m_axis_tvalid && m_axis_tuser == atrm_pkg::CASE_FREEFALL) |-> (ent_q[0] == ONE && ent_q[4] == ONE && ent_q[8] == ONE), "freefall matrix is not the identity")
  `ATRM_ASSERT(a_lock_r22_zero, (m_axis_tvalid && m_axis_tuser == atrm_pkg::CASE_LOCK) |-> (ent_q[8] == '0), "gimbal lock matrix has a non-zero r22")

endmodule

/* bench/accel_tilt_rotation_matrix_tb.sv */
// Self-checking bench for the accelerometer tilt rotation matrix block.
// Needs atrm_pkg and accel_tilt_rotation_matrix; predicts each matrix in a scoreboard class.
`timescale 1ns / 1ps

module accel_tilt_rotation_matrix_tb;

  localparam int SW    = atrm_pkg::SAMPLE_WIDTH_DEF;
  localparam int FB    = atrm_pkg::FRAC_BITS_DEF;
  localparam int IN_W  = ((3 * SW + 7) / 8) * 8;
  localparam int OUT_W = ((9 * (FB + 2) + 7) / 8) * 8;
  localparam int LATENCY = 3 * FB + 9;

  // Frame codes for the frame_mode register.
  localparam logic [1:0] FRAME_NED    = 2'd0;
  localparam logic [1:0] FRAME_NED2   = 2'd1;
  localparam logic [1:0] FRAME_SPARE  = 2'd3;
  localparam logic [2:0] ADDR_FRAME   = 3'd0;

  typedef struct {
    logic signed [15:0] r [9];
    atrm_pkg::case_e    code;
  } matrix_t;

  // Holds the frame setting and the queue of predicted matrices.
  class tilt_scoreboard;
    logic [1:0] frame;
    matrix_t    pending [$];
    int         errors;

    function new();
      frame  = FRAME_NED;
      errors = 0;
    endfunction

    // Rounded magnitude of sqrt(n1*n2/(d1*d2)) scaled by 2^FB, capped at one.
    function longint unsigned root_ratio(longint unsigned n1, longint unsigned n2,
                                         longint unsigned d1, longint unsigned d2);
      logic [255:0]    rhs, lhs;
      longint unsigned lo, hi, mid, o;
      lo  = 0;
      hi  = 64'd1 << FB;
      rhs = 256'(n1) * 256'(n2) * (256'd1 << (2 * FB + 2));
      while (lo < hi) begin
        mid = lo + (hi - lo + 1) / 2;
        o   = 2 * mid - 1;
        lhs = 256'(o) * 256'(o) * 256'(d1) * 256'(d2);
        if (lhs <= rhs) lo = mid;
        else hi = mid - 1;
      end
      return lo;
    endfunction

    function logic signed [15:0] entry(bit neg, longint unsigned n1,
                                       longint unsigned n2, longint unsigned d1,
                                       longint unsigned d2);
      logic signed [15:0] q;
      q = 16'(root_ratio(n1, n2, d1, d2));
      return neg ? -q : q;
    endfunction

    // Note an accepted sample: work out its matrix and queue it.
    function void note_sample(logic signed [15:0] x, logic signed [15:0] y,
                              logic signed [15:0] z);
      matrix_t            m;
      longint unsigned    ax, ay, az, s, syz, sxz;
      bit                 xn, yn, zn;
      logic signed [15:0] one;
      one = 16'sd1 << FB;
      xn = x < 0; yn = y < 0; zn = z < 0;
      ax = xn ? -longint'(x) : longint'(x);
      ay = yn ? -longint'(y) : longint'(y);
      az = zn ? -longint'(z) : longint'(z);
      s  = ax * ax + ay * ay + az * az;
      syz = ay * ay + az * az;
      sxz = ax * ax + az * az;
      foreach (m.r[k]) m.r[k] = '0;
      m.code = atrm_pkg::CASE_GENERAL;
      if (s == 0) begin
        m.r[0] = one; m.r[4] = one; m.r[8] = one;
        m.code = atrm_pkg::CASE_FREEFALL;
      end else if (frame != atrm_pkg::FRAME_WIN) begin
        if (syz == 0) begin
          m.r[4] = one;
          m.r[2] = xn ? -one : one;
          m.r[6] = xn ? one : -one;
          m.code = atrm_pkg::CASE_LOCK;
        end else begin
          m.r[2] = entry(xn, ax, ax, s, 1);
          m.r[5] = entry(yn, ay, ay, s, 1);
          m.r[8] = entry(zn, az, az, s, 1);
          m.r[0] = entry(0, syz, 1, s, 1);
          m.r[3] = entry(xn == yn, ax * ay, ax * ay, s, syz);
          m.r[6] = entry(xn == zn, ax * az, ax * az, s, syz);
          m.r[4] = entry(zn, az, az, syz, 1);
          m.r[7] = entry(!yn, ay, ay, syz, 1);
        end
      end else begin
        if (sxz == 0) begin
          m.r[0] = one;
          m.r[5] = yn ? one : -one;
          m.r[7] = yn ? -one : one;
          m.code = atrm_pkg::CASE_LOCK;
        end else begin
          m.r[2] = entry(!xn, ax, ax, s, 1);
          m.r[5] = entry(!yn, ay, ay, s, 1);
          m.r[8] = entry(!zn, az, az, s, 1);
          m.r[0] = entry(0, az, az, sxz, 1);
          m.r[6] = entry(xn == zn, ax, ax, sxz, 1);
          m.r[1] = entry((xn != yn) != zn, ax * ay, ax * ay, s, sxz);
          m.r[4] = entry(!zn, sxz, 1, s, 1);
          m.r[7] = entry(yn, ay * az, ay * az, s, sxz);
        end
      end
      pending.push_back(m);
    endfunction

    // Compare one output beat against the oldest prediction.
    function void check_matrix(logic [OUT_W-1:0] data, logic [1:0] user);
      matrix_t            m;
      logic signed [15:0] got;
      if (pending.size() == 0) begin
        $error("matrix beat with nothing expected: data=%h case=%0d", data, user);
        errors++;
        return;
      end
      m = pending.pop_front();
      for (int k = 0; k < 9; k++) begin
        got = data[k*16 +: 16];
        if (got !== m.r[k]) begin
          $error("r%0d%0d: expected %0d, got %0d", k / 3, k % 3, m.r[k], got);
          errors++;
        end
      end
      if (user !== m.code) begin
        $error("case_code: expected %0d, got %0d", m.code, user);
        errors++;
      end
    endfunction
  endclass

  logic             clk_i, rst_ni;
  logic             s_axis_tvalid, s_axis_tready;
  logic [IN_W-1:0]  s_axis_tdata;   // accel_x, accel_y, accel_z
  logic             m_axis_tvalid, m_axis_tready;
  logic [OUT_W-1:0] m_axis_tdata;   // r00 r01 r02 r10 r11 r12 r20 r21 r22
  logic [1:0]       m_axis_tuser;   // case_code
  logic             psel, penable, pwrite, pready;
  logic [2:0]       paddr;
  logic [31:0]      pwdata, prdata;

  tilt_scoreboard tilt_sb;
  int  send_idle_pct, recv_idle_pct;
  bit  recv_hold;     // long receiver hold-off in progress

  accel_tilt_rotation_matrix i_dut (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    #50ms;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Receiver: drop tready at random, or hold it low during a long hold-off.
  always @(posedge clk_i) begin
    if (!rst_ni) m_axis_tready <= 1'b0;
    else m_axis_tready <= !recv_hold && ($urandom_range(99) >= recv_idle_pct);
  end

  // Check every accepted output beat.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) tilt_sb.check_matrix(m_axis_tdata, m_axis_tuser);
  end

  // Offer one sample, with a random gap ahead, and wait for its acceptance.
  task automatic send_sample(logic signed [15:0] x, logic signed [15:0] y,
                             logic signed [15:0] z);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= IN_W'({z, y, x});
    do @(posedge clk_i); while (!s_axis_tready);
    tilt_sb.note_sample(x, y, z);
  endtask

  // Wait for every predicted matrix, then let the pipeline settle.
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (tilt_sb.pending.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 8) @(posedge clk_i);
  endtask

  // Write the frame register with an APB setup phase and an access phase.
  task automatic write_frame(logic [1:0] mode);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_FRAME;
    pwdata  <= 32'(mode);
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    tilt_sb.frame = mode;
  endtask

  // Random field: mostly full range, sometimes zero or an extreme or a small value.
  function automatic logic signed [15:0] rand_axis();
    case ($urandom_range(9))
      0: return 16'sd0;
      1: return 16'sh8000;
      2: return 16'sh7fff;
      3: return 16'($signed($urandom_range(8)) - 4);
      default: return 16'($urandom);
    endcase
  endfunction

  // Random sample that often lands on the special cases.
  task automatic send_random(int count);
    logic signed [15:0] x, y, z;
    repeat (count) begin
      x = rand_axis(); y = rand_axis(); z = rand_axis();
      case ($urandom_range(19))
        0: begin x = 0; y = 0; z = 0; end
        1: begin y = 0; z = 0; end
        2: begin x = 0; z = 0; end
        default: ;
      endcase
      send_sample(x, y, z);
    end
  endtask

  initial begin
    logic [1:0] frames [4];
    frames = '{FRAME_NED, atrm_pkg::FRAME_WIN, FRAME_NED2, FRAME_SPARE};
    tilt_sb = new();
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    send_idle_pct = 0; recv_idle_pct = 0;
    recv_hold = 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: freefall, both gimbal locks, extremes, one per frame.
    foreach (frames[f]) begin
      write_frame(frames[f]);
      send_sample(0, 0, 0);
      send_sample(16'sh7fff, 0, 0);
      send_sample(16'sh8000, 0, 0);
      send_sample(0, 16'sh7fff, 0);
      send_sample(0, 16'sh8000, 0);
      send_sample(16'sh8000, 16'sh8000, 16'sh8000);
      send_sample(16'sh7fff, 16'sh8000, 16'sh7fff);
      send_sample(-1, 1, -1);
      send_sample(3, -4, 0);
      drain();
    end

    // Random phases: idle mixes from the settings, each under several frames.
    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 16 : (phase == 1) ? 82 : 0;
      recv_idle_pct = (phase == 0) ? 82 : (phase == 1) ? 16 : 0;
      foreach (frames[f]) begin
        write_frame(frames[f]);
        send_random(36);
        drain();
      end
    end

    // Hold the receiver off for a long stretch while samples keep coming.
    send_idle_pct = 0; recv_idle_pct = 0;
    write_frame(atrm_pkg::FRAME_WIN);
    fork
      begin
        recv_hold = 1'b1;
        repeat (4 * LATENCY) @(posedge clk_i);
        recv_hold = 1'b0;
      end
      send_random(60);
    join
    drain();
    write_frame(FRAME_NED);
    send_random(20);
    drain();

    if (tilt_sb.errors == 0 && tilt_sb.pending.size() == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

/* sim.f */
+incdir+sv
sv/atrm_pkg.sv
sv/atrm_front.sv
sv/atrm_div.sv
sv/atrm_sqrt.sv
sv/accel_tilt_rotation_matrix.sv
bench/accel_tilt_rotation_matrix_tb.sv
